// ----- src/lifo_pkg.sv -----
// ----------------------------------------------------------------------------
// lifo_pkg
// Shared widths, codes and controller/datapath types for the bounded stack.
// ----------------------------------------------------------------------------
package lifo_pkg;

  // default number of stack entries
  localparam int unsigned DEPTH_DEF = 16;

  // payload widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 4;

  typedef logic signed [WORD_W-1:0] word_t;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_e;

  // status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // result selection for the output register
  typedef enum logic [2:0] {
    RES_PUSH,
    RES_FULL,
    RES_EMPTY,
    RES_HIT,
    RES_MISS
  } res_sel_e;

  // controller to datapath commands
  typedef struct packed {
    logic     push_wr;   // write word at top, count up
    logic     pop_dec;   // count down
    logic     rd_top;    // read top entry, load pointer and key
    logic     rd_next;   // step pointer down, read next entry
    logic     out_load;  // load output register
    res_sel_e sel;
  } dp_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic hit;       // registered read data equals key
    logic ptr_zero;
    logic out_free;  // output register empty or being taken
  } dp_stat_t;

endpackage

// ----- src/lifo_if.sv -----
// ----------------------------------------------------------------------------
// lifo_if
// Valid/ready channels for stack commands and stack results.
// ----------------------------------------------------------------------------
interface lifo_req_if;
  import lifo_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  word_t             word;

  modport source (output valid, cmd, word, input ready);
  modport sink   (input valid, cmd, word, output ready);
endinterface

interface lifo_rsp_if;
  import lifo_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;
  word_t               value;

  modport source (output valid, status, position, value, input ready);
  modport sink   (input valid, status, position, value, output ready);
endinterface

// ----- src/lifo_ctrl.sv -----
// ----------------------------------------------------------------------------
// lifo_ctrl
// Controller state machine: decodes commands and sequences reads and scans.
// ----------------------------------------------------------------------------
module lifo_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    valid,
  input  logic [lifo_pkg::CMD_W-1:0] cmd,
  output logic                    ready,
  input  lifo_pkg::dp_stat_t      stat,
  output lifo_pkg::dp_ctl_t       ctl
);
  import lifo_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    ready      = 1'b0;
    ctl        = '{push_wr: 1'b0, pop_dec: 1'b0, rd_top: 1'b0, rd_next: 1'b0,
                   out_load: 1'b0, sel: RES_EMPTY};
    unique case (state)
      S_IDLE: begin
        ready = stat.out_free;
        if (valid && stat.out_free) begin
          unique case (cmd_e'(cmd))
            CMD_PUSH: begin
              ctl.out_load = 1'b1;
              if (stat.full) begin
                ctl.sel = RES_FULL;
              end else begin
                ctl.push_wr = 1'b1;
                ctl.sel     = RES_PUSH;
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (stat.empty) begin
                ctl.out_load = 1'b1;
              end else begin
                ctl.pop_dec = (cmd_e'(cmd) == CMD_POP);
                ctl.rd_top  = 1'b1;
                state_next  = S_READ;
              end
            end
            CMD_SEARCH: begin
              if (stat.empty) begin
                ctl.out_load = 1'b1;
              end else begin
                ctl.rd_top = 1'b1;
                state_next = S_SCAN;
              end
            end
            default: begin
              ctl.out_load = 1'b1;
            end
          endcase
        end
      end
      // top entry is in the read register
      S_READ: begin
        ctl.out_load = 1'b1;
        ctl.sel      = RES_HIT;
        state_next   = S_IDLE;
      end
      // compare one entry per cycle, walking down
      S_SCAN: begin
        if (stat.hit) begin
          ctl.out_load = 1'b1;
          ctl.sel      = RES_HIT;
          state_next   = S_IDLE;
        end else if (stat.ptr_zero) begin
          ctl.out_load = 1'b1;
          ctl.sel      = RES_MISS;
          state_next   = S_IDLE;
        end else begin
          ctl.rd_next = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/lifo_dp.sv -----
// ----------------------------------------------------------------------------
// lifo_dp
// Datapath: entry memory, count, scan pointer, key and output register.
// ----------------------------------------------------------------------------
module lifo_dp #(
  parameter int unsigned DEPTH = lifo_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  lifo_pkg::word_t     word,
  input  lifo_pkg::dp_ctl_t   ctl,
  output lifo_pkg::dp_stat_t  stat,
  lifo_rsp_if.source          rsp
);
  import lifo_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  word_t           mem [DEPTH];
  word_t           rdata;
  word_t           key;
  logic [CW-1:0]   count;
  logic [AW-1:0]   ptr;
  logic [AW-1:0]   idx_top;
  logic [AW-1:0]   raddr;
  logic            out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [POS_W-1:0]    out_position;
  word_t               out_value;

  assign idx_top = AW'(count - CW'(1));
  assign raddr   = ctl.rd_next ? (ptr - AW'(1)) : idx_top;

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (ctl.push_wr) begin
      mem[count[AW-1:0]] <= word;
    end
    rdata <= mem[raddr];
  end

  // stored entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.push_wr) begin
      count <= count + CW'(1);
    end else if (ctl.pop_dec) begin
      count <= count - CW'(1);
    end
  end

  // scan pointer and search key
  always_ff @(posedge clk) begin
    if (ctl.rd_top) begin
      ptr <= idx_top;
      key <= word;
    end else if (ctl.rd_next) begin
      ptr <= ptr - AW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      unique case (ctl.sel)
        RES_PUSH: begin
          out_status   <= ST_OK;
          out_position <= POS_W'(count);
          out_value    <= '0;
        end
        RES_FULL: begin
          out_status   <= ST_FULL;
          out_position <= POS_W'(DEPTH - 1);
          out_value    <= '0;
        end
        RES_HIT: begin
          out_status   <= ST_OK;
          out_position <= POS_W'(ptr);
          out_value    <= rdata;
        end
        RES_MISS: begin
          out_status   <= ST_NOTFOUND;
          out_position <= '0;
          out_value    <= '0;
        end
        default: begin
          out_status   <= ST_EMPTY;
          out_position <= '0;
          out_value    <= '0;
        end
      endcase
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.position = out_position;
  assign rsp.value    = out_value;

  // status back to the controller
  assign stat.empty    = (count == '0);
  assign stat.full     = (count == CW'(DEPTH));
  assign stat.hit      = (rdata == key);
  assign stat.ptr_zero = (ptr == '0);
  assign stat.out_free = !out_valid || rsp.ready;

endmodule

// ----- src/bounded_lifo_stack_with_search.sv -----
// Push (also into a full stack) and pop, peek or search on an empty stack load
// the result register on acceptance; pop and peek first read the top entry.
// Throughput: one command at a time; search time is set by the single read
// port of the entry memory, one entry compared per cycle from the top down.
// A new command is accepted only in the idle state, once the result register is free or being taken.
// Reset clears the entry count and the result valid; entry memory is not cleared.
// ----------------------------------------------------------------------------
// bounded_lifo_stack_with_search
// Bounded LIFO stack of signed words with push, pop, peek and top-down search.
// ----------------------------------------------------------------------------
module bounded_lifo_stack_with_search #(
  parameter int unsigned DEPTH = lifo_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lifo_req_if.sink    req,
  lifo_rsp_if.source  rsp
);
  import lifo_pkg::*;

  dp_ctl_t  ctl;
  dp_stat_t stat;

  // controller
  lifo_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .valid (req.valid),
    .cmd   (req.cmd),
    .ready (req.ready),
    .stat  (stat),
    .ctl   (ctl)
  );

  // datapath
  lifo_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .word (req.word),
    .ctl  (ctl),
    .stat (stat),
    .rsp  (rsp)
  );

`ifndef NO_ASSERTIONS
  // no push is issued into a full stack
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(ctl.push_wr && stat.full))
    else $error("push issued while stack full");

  // the result register is only loaded when it is free
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!rsp.valid || rsp.ready))
    else $error("result register overwritten");

  // no new transaction while a scan is stepping
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.rd_next |-> !req.ready)
    else $error("command accepted during search");

  // pop on an empty stack reports empty on the next cycle
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.cmd == CMD_POP && stat.empty)
      |=> (rsp.valid && rsp.status == ST_EMPTY))
    else $error("pop on empty stack not reported");
`endif

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded stack: a directed table of corner
// commands, then randomized push/pop/peek/search traffic under varying
// backpressure, results scored against table values or a behavioral stack image.
// ----------------------------------------------------------------------------
module tb_top;
  import lifo_pkg::*;

  localparam int unsigned STACK_DEPTH = DEPTH_DEF;
  localparam int          HALF_PERIOD = 6;
  localparam int          HOLDOFF_CYCLES = 80;
  localparam int          PHASE_ITEMS = 350;
  localparam int          DRAIN_LIMIT = 20000;

  typedef struct packed {
    status_e          status;
    logic [POS_W-1:0] position;
    word_t            value;
  } stack_rsp_t;

  typedef struct {
    cmd_e             op;
    word_t            key;
    int               reps;
    bit               typed;
    status_e          status;
    logic [POS_W-1:0] position;
    word_t            value;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lifo_req_if req_ch ();
  lifo_rsp_if rsp_ch ();

  bounded_lifo_stack_with_search #(.DEPTH(STACK_DEPTH)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // behavioral stack image
  word_t      stack_image [STACK_DEPTH];
  int         stack_fill = 0;
  stack_rsp_t pending_results [$];
  int         mismatches = 0;

  // side info travelling with the item on the request channel
  bit         drv_typed;
  stack_rsp_t drv_expect;

  // idle rates in percent and long receiver hold-off request
  int tx_idle_pct = 7;
  int rx_idle_pct = 65;
  bit holdoff_request = 1'b0;

  // values reused often so that searches find matches
  word_t key_pool [8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                          32'h0000_0001, 32'h0000_0002, 32'h5555_5555, 32'hAAAA_AAAA};

  // directed corners, typed expectations where obvious
  dir_row_t dir_rows [24] = '{
    '{CMD_POP,    32'h0000_0000,  1, 1, ST_EMPTY,    4'd0,  32'h0000_0000},
    '{CMD_PEEK,   32'h0000_0000,  1, 1, ST_EMPTY,    4'd0,  32'h0000_0000},
    '{CMD_SEARCH, 32'h0000_0000,  1, 1, ST_EMPTY,    4'd0,  32'h0000_0000},
    '{CMD_PUSH,   32'h8000_0000,  1, 1, ST_OK,       4'd0,  32'h0000_0000},
    '{CMD_PUSH,   32'h7FFF_FFFF,  1, 1, ST_OK,       4'd1,  32'h0000_0000},
    '{CMD_PUSH,   32'h0000_0000,  1, 1, ST_OK,       4'd2,  32'h0000_0000},
    '{CMD_PUSH,   32'hFFFF_FFFF,  1, 1, ST_OK,       4'd3,  32'h0000_0000},
    '{CMD_PEEK,   32'h0000_0000,  1, 1, ST_OK,       4'd3,  32'hFFFF_FFFF},
    '{CMD_SEARCH, 32'h8000_0000,  1, 1, ST_OK,       4'd0,  32'h8000_0000},
    '{CMD_SEARCH, 32'h0000_0005,  1, 1, ST_NOTFOUND, 4'd0,  32'h0000_0000},
    '{CMD_SEARCH, 32'h7FFF_FFFF,  1, 1, ST_OK,       4'd1,  32'h7FFF_FFFF},
    '{CMD_POP,    32'h0000_0000,  1, 1, ST_OK,       4'd3,  32'hFFFF_FFFF},
    '{CMD_PUSH,   32'h0000_002A,  1, 1, ST_OK,       4'd3,  32'h0000_0000},
    '{CMD_PUSH,   32'h0000_002A,  1, 1, ST_OK,       4'd4,  32'h0000_0000},
    '{CMD_SEARCH, 32'h0000_002A,  1, 1, ST_OK,       4'd4,  32'h0000_002A},
    '{CMD_PUSH,   32'h0000_03E8, 11, 0, ST_OK,       4'd0,  32'h0000_0000},
    '{CMD_PUSH,   32'h0000_004D,  1, 1, ST_FULL,     4'd15, 32'h0000_0000},
    '{CMD_SEARCH, 32'h8000_0000,  1, 1, ST_OK,       4'd0,  32'h8000_0000},
    '{CMD_SEARCH, 32'h0000_0005,  1, 1, ST_NOTFOUND, 4'd0,  32'h0000_0000},
    '{CMD_PEEK,   32'h0000_0000,  1, 0, ST_OK,       4'd0,  32'h0000_0000},
    '{CMD_POP,    32'h0000_0000, 16, 0, ST_OK,       4'd0,  32'h0000_0000},
    '{CMD_POP,    32'h0000_0000,  1, 1, ST_EMPTY,    4'd0,  32'h0000_0000},
    '{CMD_SEARCH, 32'h0000_0001,  1, 1, ST_EMPTY,    4'd0,  32'h0000_0000},
    '{CMD_PUSH,   32'hA5A5_5A5A,  1, 0, ST_OK,       4'd0,  32'h0000_0000}
  };

  // clock
  always #HALF_PERIOD clk = ~clk;

  // stack behavior for one command, updates the image
  function automatic stack_rsp_t apply_command(cmd_e op, word_t key);
    stack_rsp_t r;
    bit         found;
    r.status   = ST_OK;
    r.position = '0;
    r.value    = '0;
    found      = 1'b0;
    case (op)
      CMD_PUSH: begin
        if (stack_fill >= STACK_DEPTH) begin
          r.status   = ST_FULL;
          r.position = POS_W'(STACK_DEPTH - 1);
        end else begin
          stack_image[stack_fill] = key;
          r.position = POS_W'(stack_fill);
          stack_fill++;
        end
      end
      CMD_POP: begin
        if (stack_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          stack_fill--;
          r.position = POS_W'(stack_fill);
          r.value    = stack_image[stack_fill];
        end
      end
      CMD_PEEK: begin
        if (stack_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.position = POS_W'(stack_fill - 1);
          r.value    = stack_image[stack_fill - 1];
        end
      end
      default: begin
        if (stack_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // top-down scan, first match wins
          for (int i = stack_fill - 1; i >= 0; i--) begin
            if (!found && stack_image[i] == key) begin
              found      = 1'b1;
              r.position = POS_W'(i);
              r.value    = stack_image[i];
            end
          end
          if (!found) r.status = ST_NOTFOUND;
        end
      end
    endcase
    return r;
  endfunction

  // weighted command choice per traffic mode
  function automatic cmd_e pick_command(int mode);
    int r;
    int push_w;
    int pop_w;
    r = $urandom_range(99);
    case (mode)
      1: begin
        push_w = 70;
        pop_w  = 5;
      end
      2: begin
        push_w = 10;
        pop_w  = 60;
      end
      default: begin
        push_w = 40;
        pop_w  = 25;
      end
    endcase
    if (r < push_w) return CMD_PUSH;
    if (r < push_w + pop_w) return CMD_POP;
    if (r < push_w + pop_w + 10) return CMD_PEEK;
    return CMD_SEARCH;
  endfunction

  // one transaction on the request channel, called at a falling edge
  task automatic send_command(cmd_e op, word_t key, bit typed, stack_rsp_t expect_rsp);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd   <= op;
    req_ch.word  <= key;
    drv_typed    <= typed;
    drv_expect   <= expect_rsp;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // stop offering until every outstanding result has come back
  task automatic drain_pending();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // scoreboard: score the result first, then record the new expectation
  always @(posedge clk) begin
    stack_rsp_t got_exp;
    stack_rsp_t pred;
    if (!rst) begin
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d position %0d value %0d",
                 rsp_ch.status, rsp_ch.position, rsp_ch.value);
          mismatches++;
        end else begin
          got_exp = pending_results.pop_front();
          if (rsp_ch.status !== got_exp.status) begin
            $error("status: expected %0d, got %0d", got_exp.status, rsp_ch.status);
            mismatches++;
          end
          if (rsp_ch.position !== got_exp.position) begin
            $error("position: expected %0d, got %0d", got_exp.position, rsp_ch.position);
            mismatches++;
          end
          if (rsp_ch.value !== got_exp.value) begin
            $error("value: expected %0d, got %0d", got_exp.value, rsp_ch.value);
            mismatches++;
          end
        end
      end
      if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
        pred = apply_command(cmd_e'(req_ch.cmd), req_ch.word);
        if (drv_typed) pending_results.push_back(drv_expect);
        else pending_results.push_back(pred);
      end
    end
  end

  // result receiver with random stalls and a counted long hold-off
  initial begin
    int holdoff_left;
    holdoff_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_left > 0) begin
        rsp_ch.ready <= 1'b0;
        holdoff_left--;
      end else if (holdoff_request) begin
        holdoff_request = 1'b0;
        holdoff_left    = HOLDOFF_CYCLES - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // stimulus and end of run
  initial begin
    stack_rsp_t no_rsp;
    stack_rsp_t row_rsp;
    int         mode;
    int         wait_cycles;
    cmd_e       op;
    word_t      key;
    no_rsp       = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd   = CMD_PUSH;
    req_ch.word  = '0;
    drv_typed    = 1'b0;
    drv_expect   = '0;
    mode         = 0;

    // reset
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[n]) begin
      row_rsp.status   = dir_rows[n].status;
      row_rsp.position = dir_rows[n].position;
      row_rsp.value    = dir_rows[n].value;
      for (int k = 0; k < dir_rows[n].reps; k++) begin
        send_command(dir_rows[n].op, dir_rows[n].key + word_t'(k), dir_rows[n].typed,
                     row_rsp);
      end
    end

    // random traffic in three idle profiles
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 7;
          rx_idle_pct = 65;
        end
        1: begin
          tx_idle_pct = 65;
          rx_idle_pct = 7;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) mode = $urandom_range(2);
        // receiver stops for a long stretch while requests keep coming
        if (n == 100) holdoff_request = 1'b1;
        if (n == 200) drain_pending();
        // refresh a pool slot now and then
        if (n % 16 == 0) key_pool[$urandom_range(7)] = word_t'($urandom);
        op  = pick_command(mode);
        key = ($urandom_range(1) == 1) ? key_pool[$urandom_range(7)] : word_t'($urandom);
        send_command(op, key, 1'b0, no_rsp);
      end
    end

    // wait for outstanding results, then keep idling before the final check
    req_ch.valid <= 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (2 * STACK_DEPTH + 4) @(negedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(300000 * 2 * HALF_PERIOD);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/lifo_pkg.sv
src/lifo_if.sv
src/lifo_ctrl.sv
src/lifo_dp.sv
src/bounded_lifo_stack_with_search.sv
verif/tb_top.sv
